/* hdl/sha256_pkg.sv */
// Shared types, constants and the rotate function for the SHA-256 hasher.
package sha256_pkg;

   // Command word passed from the front end to the compression engine
   localparam logic [1:0] CMD_BYTE = 2'd0;
   localparam logic [1:0] CMD_END  = 2'd1;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] data;
   } cmd_type;

   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = 2;

   localparam logic [7:0] PAD_BYTE = 8'h80;
   localparam logic [5:0] LEN_POS  = 6'd56;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

/* hdl/sha256_front.sv */
// Input front end: drops idle words and queues byte and end commands.
module sha256_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   output logic                 req_full,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_has_byte,
   input  logic                 req_last,
   output logic                 cmd_valid,
   output sha256_pkg::cmd_type  cmd_word,
   input  logic                 cmd_take
);
   sha256_pkg::cmd_type               q_ff [sha256_pkg::QUEUE_DEPTH];
   logic [sha256_pkg::QUEUE_AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [sha256_pkg::QUEUE_AW:0]     cnt_ff, cnt_in;
   // pending end command after a byte+end word
   logic                              end_ff, end_in;
   logic                              acc, n_push, do_pop;
   sha256_pkg::cmd_type               wcmd;

   function automatic logic [sha256_pkg::QUEUE_AW-1:0] QUEUE_STEP(input logic b);
      QUEUE_STEP = {{(sha256_pkg::QUEUE_AW-1){1'b0}}, b};
   endfunction

   // Room for two entries lets a byte+end word queue both commands
   assign req_full  = end_ff || (cnt_ff > 3'(sha256_pkg::QUEUE_DEPTH - 2));
   assign acc       = req_push && !req_full;
   assign cmd_valid = cnt_ff != '0;
   assign cmd_word  = q_ff[rd_ff];
   assign do_pop    = cmd_valid && cmd_take;

   // Classify the accepted word
   always_comb begin
      n_push    = 1'b0;
      end_in    = end_ff;
      wcmd.cmd  = sha256_pkg::CMD_BYTE;
      wcmd.data = req_data_byte;
      if (end_ff) begin
         n_push   = 1'b1;
         end_in   = 1'b0;
         wcmd.cmd = sha256_pkg::CMD_END;
      end else if (acc) begin
         if (req_has_byte) begin
            n_push = 1'b1;
            end_in = req_last;
         end else if (req_last) begin
            n_push   = 1'b1;
            wcmd.cmd = sha256_pkg::CMD_END;
         end
      end
      wr_in  = wr_ff + QUEUE_STEP(n_push);
      rd_in  = rd_ff + QUEUE_STEP(do_pop);
      cnt_in = cnt_ff + {2'b0, n_push} - {2'b0, do_pop};
   end

   // Queue storage
   always_ff @(posedge clock) begin
      if (n_push) q_ff[wr_ff] <= wcmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
         end_ff <= 1'b0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
         end_ff <= end_in;
      end
   end
endmodule

/* hdl/sha256_engine.sv */
// Back end: block buffer, padding, 64-round compression and digest output.
module sha256_engine (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 cmd_valid,
   input  sha256_pkg::cmd_type  cmd_word,
   output logic                 cmd_take,
   output logic                 rsp_empty,
   input  logic                 rsp_pop,
   output logic [31:0]          rsp_digest_word,
   output logic [2:0]           rsp_word_index,
   output logic                 rsp_last_word
);
   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_LOAD = 3'd1;
   localparam logic [2:0] ST_RND  = 3'd2;
   localparam logic [2:0] ST_ADD  = 3'd3;
   localparam logic [2:0] ST_PAD  = 3'd4;
   localparam logic [2:0] ST_OUT  = 3'd5;

   logic [2:0]   st_ff, st_in;
   logic [31:0]  blk_ff [16];       // block buffer as 16 big-endian words
   logic [31:0]  w_ff [16];         // schedule window, w_ff[0] is current
   logic [31:0]  v_ff [8];
   logic [31:0]  h_ff [8];
   logic [60:0]  cnt_ff;
   logic [5:0]   rnd_ff;
   logic         fin_ff;            // compressing a final block
   logic         two_ff;            // length goes in a second block
   logic         blk_pass2_ff;      // second pad pass of a two-block tail
   logic [2:0]   oi_ff;
   logic [31:0]  w_new, t1, t2, s0, s1, wcur;
   logic [5:0]   pos;

   assign pos             = cnt_ff[5:0];
   assign cmd_take        = (st_ff == ST_IDLE) && cmd_valid;
   assign rsp_empty       = st_ff != ST_OUT;
   assign rsp_digest_word = h_ff[oi_ff];
   assign rsp_word_index  = oi_ff;
   assign rsp_last_word   = oi_ff == 3'd7;

   // One round of the compression function
   always_comb begin
      wcur  = w_ff[0];
      s0    = sha256_pkg::rotr(w_ff[1], 7) ^ sha256_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
      s1    = sha256_pkg::rotr(w_ff[14], 17) ^ sha256_pkg::rotr(w_ff[14], 19)
              ^ (w_ff[14] >> 10);
      w_new = w_ff[0] + s0 + w_ff[9] + s1;
      t1 = v_ff[7] + (sha256_pkg::rotr(v_ff[4], 6) ^ sha256_pkg::rotr(v_ff[4], 11)
           ^ sha256_pkg::rotr(v_ff[4], 25)) + ((v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]))
           + sha256_pkg::ROUND_K[rnd_ff] + wcur;
      t2 = (sha256_pkg::rotr(v_ff[0], 2) ^ sha256_pkg::rotr(v_ff[0], 13)
           ^ sha256_pkg::rotr(v_ff[0], 22))
           + ((v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]));
   end

   // Sequencer state
   always_comb begin
      st_in = st_ff;
      unique case (st_ff)
         ST_IDLE: if (cmd_valid) begin
            if (cmd_word.cmd == sha256_pkg::CMD_END) st_in = ST_PAD;
            else if (pos == 6'd63) st_in = ST_LOAD;
         end
         ST_PAD:  st_in = ST_LOAD;
         ST_LOAD: st_in = ST_RND;
         ST_RND:  if (rnd_ff == 6'd63) st_in = ST_ADD;
         ST_ADD:  st_in = !fin_ff ? ST_IDLE : (two_ff ? ST_PAD : ST_OUT);
         ST_OUT:  if (rsp_pop && oi_ff == 3'd7) st_in = ST_IDLE;
         default: st_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff  <= ST_IDLE;
         cnt_ff <= '0;
         fin_ff <= 1'b0;
         two_ff <= 1'b0;
         oi_ff  <= '0;
         rnd_ff <= '0;
         for (int i = 0; i < 8; i++) h_ff[i] <= sha256_pkg::INIT_HASH[i];
      end else begin
         st_ff <= st_in;
         unique case (st_ff)
            ST_IDLE: if (cmd_valid) begin
               if (cmd_word.cmd == sha256_pkg::CMD_END) begin
                  fin_ff <= 1'b1;
                  two_ff <= pos >= sha256_pkg::LEN_POS;
               end else begin
                  cnt_ff <= cnt_ff + 61'd1;
                  fin_ff <= 1'b0;
               end
            end
            ST_PAD: if (two_ff) begin
               // second pass: clear first pass's data and exit after it
            end
            ST_LOAD: rnd_ff <= '0;
            ST_RND:  rnd_ff <= rnd_ff + 6'd1;
            ST_ADD: begin
               for (int i = 0; i < 8; i++) h_ff[i] <= h_ff[i] + v_ff[i];
               if (fin_ff && !two_ff) oi_ff <= '0;
            end
            ST_OUT: if (rsp_pop) begin
               oi_ff <= oi_ff + 3'd1;
               if (oi_ff == 3'd7) begin
                  for (int i = 0; i < 8; i++) h_ff[i] <= sha256_pkg::INIT_HASH[i];
                  cnt_ff <= '0;
                  fin_ff <= 1'b0;
               end
            end
            default: ;
         endcase
         // the second pad pass is the length-only block
         if (st_ff == ST_PAD && two_ff && st_in == ST_LOAD && blk_pass2_ff) two_ff <= 1'b0;
      end
   end

   // Tracks whether the first pad pass for a two-block tail has run
   always_ff @(posedge clock) begin
      if (reset) blk_pass2_ff <= 1'b0;
      else if (st_ff == ST_PAD) blk_pass2_ff <= two_ff && !blk_pass2_ff;
      else if (st_ff == ST_OUT) blk_pass2_ff <= 1'b0;
   end

   // Datapath: block buffer, schedule and working variables
   always_ff @(posedge clock) begin
      unique case (st_ff)
         ST_IDLE: if (cmd_valid && cmd_word.cmd == sha256_pkg::CMD_BYTE) begin
            blk_ff[pos[5:2]][8*(3-pos[1:0]) +: 8] <= cmd_word.data;
         end
         ST_PAD: begin
            for (int i = 0; i < 16; i++) begin
               for (int b = 0; b < 4; b++) begin
                  if (blk_pass2_ff) begin
                     if (i < 14) blk_ff[i][8*(3-b) +: 8] <= 8'h00;
                  end else if (6'(4*i+b) == pos) blk_ff[i][8*(3-b) +: 8] <= sha256_pkg::PAD_BYTE;
                  else if (6'(4*i+b) > pos) blk_ff[i][8*(3-b) +: 8] <= 8'h00;
               end
            end
            if (!(two_ff && !blk_pass2_ff)) begin
               blk_ff[14] <= cnt_ff[60:29];
               blk_ff[15] <= {cnt_ff[28:0], 3'b000};
            end
         end
         ST_LOAD: begin
            for (int i = 0; i < 16; i++) w_ff[i] <= blk_ff[i];
            for (int i = 0; i < 8; i++) v_ff[i] <= h_ff[i];
         end
         ST_RND: begin
            for (int i = 0; i < 15; i++) w_ff[i] <= w_ff[i+1];
            w_ff[15] <= w_new;
            v_ff[7] <= v_ff[6]; v_ff[6] <= v_ff[5]; v_ff[5] <= v_ff[4];
            v_ff[4] <= v_ff[3] + t1;
            v_ff[3] <= v_ff[2]; v_ff[2] <= v_ff[1]; v_ff[1] <= v_ff[0];
            v_ff[0] <= t1 + t2;
         end
         default: ;
      endcase
   end
endmodule

/* hdl/sha256_message_hasher.sv */
// SHA-256 hasher top level: front-end queue feeding the compression engine.
// The front-end queue holds accepted words until the engine is idle; a byte word is
// stored in the block buffer; a 64th byte starts a compression (load, 64 rounds, add).
// An end word pads and compresses a final block (take, pad, load, 64 rounds, add), and
// a second block follows when the length needs one; then 8 digest words are offered
// one per cycle as the consumer pops them. The queue fills while the engine is busy.
// Synchronous active-high reset restores the initial hash and clears all counts.
module sha256_message_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_push,
   output logic        req_full,
   input  logic [7:0]  req_data_byte,
   input  logic        req_has_byte,
   input  logic        req_last,
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [31:0] rsp_digest_word,
   output logic [2:0]  rsp_word_index,
   output logic        rsp_last_word
);
   logic                cmd_valid, cmd_take;
   sha256_pkg::cmd_type cmd_word;

   sha256_front u_front (
      .clock, .reset, .req_push, .req_full, .req_data_byte, .req_has_byte,
      .req_last, .cmd_valid, .cmd_word, .cmd_take
   );

   sha256_engine u_engine (
      .clock, .reset, .cmd_valid, .cmd_word, .cmd_take, .rsp_empty, .rsp_pop,
      .rsp_digest_word, .rsp_word_index, .rsp_last_word
   );
endmodule

/* sim/testbench.sv */
// Self-checking testbench for the SHA-256 message hasher.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [31:0] IV [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };
   localparam logic [31:0] KTAB [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };
   localparam longint CYCLE_LIMIT = 2000000;

   typedef struct packed {
      logic [31:0] word;
      logic [2:0]  index;
      logic        last;
   } digest_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        req_push = 0;
   logic        req_full;
   logic [7:0]  req_data_byte = 0;
   logic        req_has_byte = 0;
   logic        req_last = 0;
   logic        rsp_empty;
   logic        rsp_pop = 0;
   logic [31:0] rsp_digest_word;
   logic [2:0]  rsp_word_index;
   logic        rsp_last_word;

   // predictor state
   logic [31:0] hash_state [8];
   logic [7:0]  msg_block [64];
   logic [60:0] msg_bytes;
   digest_type  expected_digests [$];

   int   errors = 0;
   int   words_sent = 0;
   int   digests_seen = 0;
   int   long_hold = 0;
   longint cycle_count = 0;

   sha256_message_hasher DUT (.*);

   always #2 clock = ~clock;

   // run-away guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout at %0t", $time);
         $display("*** FAILED ***");
         $finish;
      end
   end

   function automatic logic [31:0] ror(logic [31:0] x, int n);
      return (x >> n) | (x << (32 - n));
   endfunction

   // one compression of msg_block into hash_state
   task automatic compress_block();
      logic [31:0] w [16];
      logic [31:0] v [8];
      logic [31:0] wt, t1, t2, a15, a2;
      for (int i = 0; i < 16; i++)
         w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int i = 0; i < 64; i++) begin
         if (i < 16) begin
            wt = w[i];
         end else begin
            a15 = w[(i - 15) & 15];
            a2 = w[(i - 2) & 15];
            wt = w[i & 15] + (ror(a15, 7) ^ ror(a15, 18) ^ (a15 >> 3)) + w[(i - 7) & 15]
                 + (ror(a2, 17) ^ ror(a2, 19) ^ (a2 >> 10));
            w[i & 15] = wt;
         end
         t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
              + ((v[4] & v[5]) ^ (~v[4] & v[6])) + KTAB[i] + wt;
         t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
              + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
         v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
         v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
   endtask

   // predict the digest words caused by one accepted word
   task automatic predict_hash(logic [7:0] data, logic has_byte, logic last);
      int pos;
      logic [63:0] bits;
      digest_type d;
      if (has_byte) begin
         pos = int'(msg_bytes[5:0]);
         msg_block[pos] = data;
         msg_bytes = msg_bytes + 61'd1;
         if (pos == 63) compress_block();
      end
      if (last) begin
         pos = int'(msg_bytes[5:0]);
         msg_block[pos] = 8'h80;
         for (int i = pos + 1; i < 64; i++) msg_block[i] = 8'h00;
         if (pos >= 56) begin
            compress_block();
            for (int i = 0; i < 56; i++) msg_block[i] = 8'h00;
         end
         bits = {msg_bytes, 3'b000};
         for (int i = 0; i < 8; i++) msg_block[63 - i] = bits[8*i +: 8];
         compress_block();
         for (int i = 0; i < 8; i++) begin
            d.word = hash_state[i];
            d.index = 3'(i);
            d.last = (i == 7);
            expected_digests.push_back(d);
         end
         hash_state = IV;
         msg_bytes = '0;
      end
   endtask

   // send one word, with an optional random gap first
   task automatic send_word(logic [7:0] data, logic has_byte, logic last, bit gaps = 1);
      int gap;
      gap = gaps ? $urandom_range(0, 16) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_push <= 0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1;
      req_data_byte <= data;
      req_has_byte <= has_byte;
      req_last <= last;
      do @(posedge clock); while (req_full);
      predict_hash(data, has_byte, last);
      if (has_byte || last) words_sent++;
   endtask

   // send a message of n random bytes, optional idle noise, then an end word or an end on the last byte
   task automatic send_message(int n, bit fuse_end, bit noise);
      for (int i = 0; i < n; i++) begin
         if (noise && $urandom_range(0, 7) == 0) send_word(8'($urandom), 0, 0);
         if (fuse_end && i == n - 1) send_word(8'($urandom), 1, 1);
         else send_word(8'($urandom), 1, 0, $urandom_range(0, 3) == 0);
      end
      if (!fuse_end || n == 0) send_word(8'($urandom), 0, 1);
   endtask

   // receiver: random pop gaps, one long hold-off when requested
   initial begin
      int gap;
      forever begin
         @(posedge clock);
         if (long_hold > 0) begin
            rsp_pop <= 0;
            long_hold--;
         end else if (rsp_pop && !rsp_empty) begin
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 16);
            if (gap > 0) begin
               rsp_pop <= 0;
               repeat (gap) @(posedge clock);
            end
            rsp_pop <= 1;
         end else begin
            rsp_pop <= 1;
         end
      end
   end

   // checker: compare each popped digest word with the oldest expectation
   always @(posedge clock) begin
      digest_type e;
      if (!reset && rsp_pop && !rsp_empty) begin
         if (expected_digests.size() == 0) begin
            $display("%0t: unexpected digest word %h", $time, rsp_digest_word);
            errors++;
         end else begin
            e = expected_digests.pop_front();
            if (e.word !== rsp_digest_word || e.index !== rsp_word_index
                || e.last !== rsp_last_word) begin
               $display("%0t: expected word %h index %0d last %b, got %h %0d %b", $time,
                        e.word, e.index, e.last, rsp_digest_word, rsp_word_index,
                        rsp_last_word);
               errors++;
            end
            digests_seen++;
         end
      end
   end

   // empty message, idle words and known vectors
   task automatic test_directed();
      send_word(8'hff, 0, 0);
      send_word(8'h00, 0, 1);
      send_word("a", 1, 0);
      send_word("b", 1, 0);
      send_word(8'h00, 0, 0);
      send_word("c", 1, 1);
      send_word(8'h00, 1, 0);
      send_word(8'hff, 1, 0);
      send_word(8'h5a, 0, 1);
   endtask

   task automatic test_block_edges();
      int sizes [3] = '{55, 56, 64};
      foreach (sizes[i]) send_message(sizes[i], i != 0, 0);
   endtask

   // stall the output so the input queue fills
   task automatic test_backpressure();
      long_hold = 600;
      for (int i = 0; i < 4; i++) send_message($urandom_range(2, 5), 0, 0);
   endtask

   task automatic test_random_messages();
      for (int m = 0; m < 6; m++) begin
         send_message($urandom_range(0, 6), $urandom_range(0, 1), 1);
      end
   endtask

   initial begin
      hash_state = IV;
      msg_bytes = '0;
      repeat (10) @(posedge clock);
      reset <= 0;
      test_directed();
      test_block_edges();
      test_backpressure();
      test_random_messages();
      req_push <= 0;
      wait (expected_digests.size() == 0);
      repeat (300) @(posedge clock);
      $display("Sent %0d message words; checked %0d digest words incl. padding edges.",
               words_sent, digests_seen);
      if (errors == 0 && expected_digests.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule

/* sim.f */
hdl/sha256_pkg.sv
hdl/sha256_front.sv
hdl/sha256_engine.sv
hdl/sha256_message_hasher.sv
sim/testbench.sv
